// ===== src/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared constants for the shortest-remaining-time scheduler: command codes,
// field widths and parameter defaults.
// ----------------------------------------------------------------------------
package srtf_pkg;

   // Parameter defaults for the top level.
   localparam int MAX_PROCS_DEF = 16;
   localparam int TIME_BITS_DEF = 24;

   // Fixed field widths of the request and response words.
   localparam int CMD_W   = 2;
   localparam int INDEX_W = 4;
   localparam int TICK_W  = 16;
   localparam int COUNT_W = 5;
   localparam int OUT_T_W = 24;

   // Command codes carried by req_cmd.
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

endpackage

// ===== src/shortest_remaining_time_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_core
// Preemptive shortest-remaining-time scheduler over a table of processes,
// built around one read port per table memory and one shared subtractor.
// ----------------------------------------------------------------------------
// Usage:
//  - Request words (req_*) carry a command: load one table entry, advance
//    time by one tick, or restart the schedule. Every request word yields
//    exactly one response word (rsp_*), in order.
//  - csr_wr_en / csr_wr_data set the number of entries that take part; write
//    it only while the block is idle.
//  - A load or an unused command is answered without a table scan. A tick
//    scans the counted entries through the table read port, one entry per
//    cycle, then updates the winner and, on completion, works out
//    turnaround and waiting time on the shared subtractor. A restart copies
//    every burst length back into the remaining-time table.
//  - req_ready is high only while the sequencer is idle, and the sequencer
//    returns to idle as the previous response is registered.
//  - The response sits in an output register, so the next request is taken
//    while a response still waits; if rsp_ready stays low, the following
//    word finishes its work and then holds until the register frees up.
//  - Reset clears time, finished marks and the previous runner; table
//    contents are undefined until loaded.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_core #(
   parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF,
   parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration
   input  logic                         csr_wr_en,
   input  logic [srtf_pkg::COUNT_W-1:0] csr_wr_data,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [srtf_pkg::CMD_W-1:0]   req_cmd,
   input  logic [srtf_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [srtf_pkg::TICK_W-1:0]  req_arrival_time,
   input  logic [srtf_pkg::TICK_W-1:0]  req_burst_length,
   // Response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_ran,
   output logic [srtf_pkg::INDEX_W-1:0] rsp_runner_index,
   output logic                         rsp_switched,
   output logic                         rsp_finished,
   output logic [srtf_pkg::OUT_T_W-1:0] rsp_completion_time,
   output logic [srtf_pkg::OUT_T_W-1:0] rsp_turnaround,
   output logic [srtf_pkg::OUT_T_W-1:0] rsp_waiting,
   output logic                         rsp_all_done
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = srtf_pkg::TICK_W;
   localparam int OW    = srtf_pkg::OUT_T_W;
   localparam int IW    = srtf_pkg::INDEX_W;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [IDX_W:0]       RUNNER_NONE = (IDX_W + 1)'(MAX_PROCS);
   localparam logic [TW:0]          REM_INIT = {1'b1, {TW{1'b0}}};

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWEEP = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_PICK  = 3'd3;
   localparam logic [2:0] ST_TURN  = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // Process table memories.
   logic [TW-1:0] arrival_mem [MAX_PROCS];
   logic [TW-1:0] burst_mem   [MAX_PROCS];
   logic [TW-1:0] remain_mem  [MAX_PROCS];

   // Control registers.
   logic [2:0]                 state_ff, state_in;
   logic [srtf_pkg::COUNT_W-1:0] pcount_ff, pcount_in;
   logic [CNT_W-1:0]           ptr_ff, ptr_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [MAX_PROCS-1:0]       fin_ff, fin_in;
   logic [TIME_BITS-1:0]       time_ff, time_in;
   logic [IDX_W:0]             prev_ff, prev_in;
   logic                       best_vld_ff, best_vld_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [TW-1:0]              rd_arr_ff, rd_bur_ff, rd_rem_ff;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic [TW:0]                best_rem_ff, best_rem_in;
   logic [TW-1:0]              best_arr_ff, best_arr_in;
   logic                       res_ran_ff, res_ran_in;
   logic                       res_sw_ff, res_sw_in;
   logic                       res_fin_ff, res_fin_in;
   logic [IDX_W-1:0]           res_idx_ff, res_idx_in;
   logic [TIME_BITS-1:0]       tat_ff, tat_in;
   logic [TIME_BITS-1:0]       wt_ff, wt_in;
   logic                       rsp_ran_ff, rsp_ran_in;
   logic [srtf_pkg::INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                       rsp_sw_ff, rsp_sw_in;
   logic                       rsp_fin_ff, rsp_fin_in;
   logic [OW-1:0]              rsp_ct_ff, rsp_ct_in;
   logic [OW-1:0]              rsp_tat_ff, rsp_tat_in;
   logic [OW-1:0]              rsp_wt_ff, rsp_wt_in;
   logic                       rsp_done_ff, rsp_done_in;

   // Memory port controls.
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic                       load_we;
   logic [IDX_W-1:0]           load_addr;
   logic [TW-1:0]              load_burst;
   logic                       rem_we;
   logic [IDX_W-1:0]           rem_waddr;
   logic [TW-1:0]              rem_wdata;

   // Shared subtractor and other helpers.
   logic [TIME_BITS-1:0]       sub_a, sub_b;
   logic [TIME_BITS:0]         sub_diff;
   logic                       sub_borrow;
   logic [TIME_BITS-1:0]       time_next;
   logic [CNT_W-1:0]           counted;
   logic [MAX_PROCS-1:0]       count_mask;
   logic                       all_done;
   logic                       accept;
   logic                       cand;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Entries taking part, with the count held to the table size.
   always_comb begin
      if (32'(pcount_ff) > MAX_PROCS) begin
         counted = CNT_W'(MAX_PROCS);
      end else begin
         counted = CNT_W'(pcount_ff);
      end
   end

   // Mask of counted entries, and the all-finished status over them.
   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         count_mask[i] = (i < 32'(counted));
      end
   end
   assign all_done = &(fin_ff | ~count_mask);

   // Saturating time step.
   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;

   // Shared subtractor; a borrow means the difference clamps at zero.
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[TIME_BITS];

   // Scan candidate: arrived, unfinished, work left, and strictly shorter.
   assign cand = (TIME_BITS'(rd_arr_ff) <= time_ff) && !fin_ff[rd_idx_ff] &&
                 (rd_rem_ff != '0) && ({1'b0, rd_rem_ff} < best_rem_ff);

   // Load port decode.
   assign load_addr  = IDX_W'(req_entry_index);
   assign load_burst = (req_burst_length == '0) ? TW'(1) : req_burst_length;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      fin_in       = fin_ff;
      time_in      = time_ff;
      prev_in      = prev_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      best_arr_in  = best_arr_ff;
      res_ran_in   = res_ran_ff;
      res_sw_in    = res_sw_ff;
      res_fin_in   = res_fin_ff;
      res_idx_in   = res_idx_ff;
      tat_in       = tat_ff;
      wt_in        = wt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ran_in   = rsp_ran_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_ct_in    = rsp_ct_ff;
      rsp_tat_in   = rsp_tat_ff;
      rsp_wt_in    = rsp_wt_ff;
      rsp_done_in  = rsp_done_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IDX_W-1:0];
      load_we      = 1'b0;
      rem_we       = 1'b0;
      rem_waddr    = rd_idx_ff;
      rem_wdata    = rd_bur_ff;
      sub_a        = time_ff;
      sub_b        = TIME_BITS'(best_arr_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_ran_in = 1'b0;
               res_sw_in  = 1'b0;
               res_fin_in = 1'b0;
               res_idx_in = '0;
               ptr_in     = '0;
               unique case (req_cmd)
                  srtf_pkg::CMD_LOAD: begin
                     load_we   = (32'(req_entry_index) < MAX_PROCS);
                     rem_we    = load_we;
                     rem_waddr = load_addr;
                     rem_wdata = load_burst;
                     state_in  = ST_DONE;
                  end
                  srtf_pkg::CMD_TICK: begin
                     best_vld_in = 1'b0;
                     best_rem_in = REM_INIT;
                     state_in    = ST_SCAN;
                  end
                  srtf_pkg::CMD_RESTART: begin
                     fin_in   = '0;
                     time_in  = '0;
                     prev_in  = RUNNER_NONE;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Copy each burst length back into the remaining-time table.
         ST_SWEEP: begin
            if (32'(ptr_ff) < MAX_PROCS) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in    = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               rem_we = 1'b1;
            end
            if ((32'(ptr_ff) >= MAX_PROCS) && !rd_vld_ff) begin
               state_in = ST_DONE;
            end
         end

         // Walk the counted entries, one compare per cycle.
         ST_SCAN: begin
            if (ptr_ff < counted) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in    = ptr_ff + 1'b1;
            end
            if (rd_vld_ff && cand) begin
               best_vld_in = 1'b1;
               best_idx_in = rd_idx_ff;
               best_rem_in = {1'b0, rd_rem_ff};
               best_arr_in = rd_arr_ff;
            end
            if ((ptr_ff >= counted) && !rd_vld_ff) begin
               state_in = ST_PICK;
            end
         end

         // Serve the winner and advance time.
         ST_PICK: begin
            sub_a    = TIME_BITS'(best_rem_ff[TW-1:0]);
            sub_b    = TIME_BITS'(1);
            time_in  = time_next;
            state_in = ST_DONE;
            if (best_vld_ff) begin
               rem_we     = 1'b1;
               rem_waddr  = best_idx_ff;
               rem_wdata  = sub_diff[TW-1:0];
               prev_in    = {1'b0, best_idx_ff};
               res_ran_in = 1'b1;
               res_idx_in = best_idx_ff;
               res_sw_in  = (prev_ff != {1'b0, best_idx_ff});
               if (sub_diff[TW-1:0] == '0) begin
                  fin_in[best_idx_ff] = 1'b1;
                  res_fin_in = 1'b1;
                  rd_en      = 1'b1;
                  rd_addr    = best_idx_ff;
                  state_in   = ST_TURN;
               end
            end
         end

         // Turnaround: completion time minus arrival, clamped at zero.
         ST_TURN: begin
            tat_in   = sub_borrow ? '0 : sub_diff[TIME_BITS-1:0];
            state_in = ST_WAIT;
         end

         // Waiting: turnaround minus burst, clamped at zero.
         ST_WAIT: begin
            sub_a    = tat_ff;
            sub_b    = TIME_BITS'(rd_bur_ff);
            wt_in    = sub_borrow ? '0 : sub_diff[TIME_BITS-1:0];
            state_in = ST_DONE;
         end

         // Hand the word to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ran_in   = res_ran_ff;
               rsp_idx_in   = IW'(res_idx_ff);
               rsp_sw_in    = res_sw_ff;
               rsp_fin_in   = res_fin_ff;
               rsp_ct_in    = res_fin_ff ? OW'(time_ff) : '0;
               rsp_tat_in   = res_fin_ff ? OW'(tat_ff) : '0;
               rsp_wt_in    = res_fin_ff ? OW'(wt_ff) : '0;
               rsp_done_in  = all_done;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         fin_ff       <= '0;
         time_ff      <= '0;
         prev_ff      <= RUNNER_NONE;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         fin_ff       <= fin_in;
         time_ff      <= time_in;
         prev_ff      <= prev_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Process count register.
   assign pcount_in = csr_wr_en ? csr_wr_data : pcount_ff;

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      best_arr_ff <= best_arr_in;
      res_ran_ff  <= res_ran_in;
      res_sw_ff   <= res_sw_in;
      res_fin_ff  <= res_fin_in;
      res_idx_ff  <= res_idx_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      rsp_ran_ff  <= rsp_ran_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_ct_ff   <= rsp_ct_in;
      rsp_tat_ff  <= rsp_tat_in;
      rsp_wt_ff   <= rsp_wt_in;
      rsp_done_ff <= rsp_done_in;
   end

   // Table memories: one write and one registered read per memory.
   always_ff @(posedge clock) begin
      if (load_we) begin
         arrival_mem[load_addr] <= req_arrival_time;
         burst_mem[load_addr]   <= load_burst;
      end
      if (rem_we) begin
         remain_mem[rem_waddr] <= rem_wdata;
      end
      if (rd_en) begin
         rd_arr_ff <= arrival_mem[rd_addr];
         rd_bur_ff <= burst_mem[rd_addr];
         rd_rem_ff <= remain_mem[rd_addr];
      end
   end

   // Response ports.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ran             = rsp_ran_ff;
   assign rsp_runner_index    = rsp_idx_ff;
   assign rsp_switched        = rsp_sw_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_completion_time = rsp_ct_ff;
   assign rsp_turnaround      = rsp_tat_ff;
   assign rsp_waiting         = rsp_wt_ff;
   assign rsp_all_done        = rsp_done_ff;

endmodule
